// File: hw/rtl/svwap_pkg.sv
// Shared types and constants for the session VWAP band unit.
`timescale 1ns / 1ps
package svwap_pkg;

   localparam int PriceW = 24;
   localparam int VolW   = 24;
   localparam int DayW   = 20;
   localparam int TodW   = 17;
   localparam int ScaleW = 12;
   localparam int SpvW   = 64;
   localparam int SvW    = 48;
   localparam int BandW  = 32;
   localparam int CsrIdxW = 3;
   localparam int CsrDatW = 17;
   localparam int NumBands = 5;

   localparam logic [CsrIdxW-1:0] CSR_RESET_TIME = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_SCALE_ONE  = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_SCALE_TWO  = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_SCALE_THREE = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_SCALE_FOUR = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_SCALE_FIVE = 3'd5;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_ANCHOR,
      OP_SUM,
      OP_DIV_SPV,
      OP_DIV_DEV,
      OP_DIV_STEP,
      OP_VWAP,
      OP_DEV,
      OP_PROD_LO,
      OP_PROD_HI,
      OP_ACC,
      OP_SQRT_INIT,
      OP_SQRT_STEP,
      OP_BAND,
      OP_WRITE
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [2:0] band_idx;
      logic       hold;
   } cmd_type;

   typedef struct packed {
      logic restart;
      logic zero_vol;
   } status_type;

endpackage

// File: hw/rtl/svwap_ctrl.sv
// Sequencer for the VWAP band unit: steps the datapath through one word.
`timescale 1ns / 1ps
module svwap_ctrl import svwap_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_ANCHOR, S_SUM, S_CHECK, S_DIV1, S_VWAP, S_DEV, S_PLO, S_PHI,
      S_ACC, S_DIV2_INIT, S_DIV2, S_SQRT_INIT, S_SQRT, S_BAND, S_OUT
   } state_type;

   state_type  state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = OP_NONE;
      cmd.band_idx = cnt_ff[2:0];
      cmd.hold     = status.zero_vol;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_ANCHOR;
            end
         end
         S_ANCHOR: begin
            cmd.op   = OP_ANCHOR;
            state_in = S_SUM;
         end
         S_SUM: begin
            cmd.op   = OP_SUM;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (status.zero_vol) begin
               state_in = S_OUT;
            end else begin
               cmd.op   = OP_DIV_SPV;
               cnt_in   = 6'd63;
               state_in = S_DIV1;
            end
         end
         S_DIV1: begin
            cmd.op = OP_DIV_STEP;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) state_in = S_VWAP;
         end
         S_VWAP: begin
            cmd.op   = OP_VWAP;
            state_in = status.restart ? S_DIV2_INIT : S_DEV;
         end
         S_DEV: begin
            cmd.op   = OP_DEV;
            state_in = S_PLO;
         end
         S_PLO: begin
            cmd.op   = OP_PROD_LO;
            state_in = S_PHI;
         end
         S_PHI: begin
            cmd.op   = OP_PROD_HI;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.op   = OP_ACC;
            state_in = S_DIV2_INIT;
         end
         S_DIV2_INIT: begin
            cmd.op   = OP_DIV_DEV;
            cnt_in   = 6'd63;
            state_in = S_DIV2;
         end
         S_DIV2: begin
            cmd.op = OP_DIV_STEP;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) state_in = S_SQRT_INIT;
         end
         S_SQRT_INIT: begin
            cmd.op   = OP_SQRT_INIT;
            cnt_in   = 6'd31;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd.op = OP_SQRT_STEP;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               cnt_in   = 6'(NumBands - 1);
               state_in = S_BAND;
            end
         end
         S_BAND: begin
            cmd.op = OP_BAND;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) state_in = S_OUT;
         end
         S_OUT: begin
            // The result register may still hold an untaken word.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = OP_WRITE;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: hw/rtl/svwap_dp.sv
// Datapath of the VWAP band unit: sums, shared divider, square root, bands.
`timescale 1ns / 1ps
module svwap_dp import svwap_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output status_type               status,
   input  logic                     csr_we,
   input  logic [CsrIdxW-1:0]       csr_index,
   input  logic [CsrDatW-1:0]       csr_data,
   input  logic [PriceW-1:0]        bar_price,
   input  logic [VolW-1:0]          bar_volume,
   input  logic [DayW-1:0]          day_number,
   input  logic [TodW-1:0]          time_of_day,
   output logic [PriceW-1:0]        vwap,
   output logic signed [BandW-1:0]  bands [2*NumBands],
   output logic                     held
);

   logic [TodW-1:0]   reset_time_ff;
   logic [ScaleW-1:0] scale_ff [NumBands];
   logic [PriceW-1:0] price_ff;
   logic [VolW-1:0]   vol_ff;
   logic [DayW-1:0]   day_ff, last_day_ff;
   logic [TodW-1:0]   tod_ff;
   logic              seen_ff, restart_ff;
   logic [47:0]       pv_ff;
   logic [SpvW-1:0]   spv_ff, swsd_ff;
   logic [SvW-1:0]    sv_ff;
   logic [63:0]       quo_ff;
   logic [SvW-1:0]    rem_ff;
   logic [PriceW-1:0] vwap_ff, vwap_out_ff;
   logic [47:0]       dsq_ff, plo_ff, phi_ff;
   logic [63:0]       x_ff, res_ff, bit_ff;
   logic signed [BandW-1:0] band_ff [2*NumBands];
   logic signed [BandW-1:0] out_ff [2*NumBands];
   logic              held_ff;

   logic [DayW-1:0]   anchor_in;
   logic [SpvW:0]     spv_sum_in;
   logic [SvW:0]      sv_sum_in;
   logic [SvW:0]      rem_sh_in;
   logic [PriceW-1:0] dev_in;
   logic [71:0]       term_in;
   logic [SpvW-1:0]   term_sat_in;
   logic [SpvW:0]     swsd_sum_in;
   logic [63:0]       trial_in;
   logic [ScaleW-1:0] scale_in;
   logic [44:0]       scaled_in;
   logic [36:0]       band_mag_in;
   logic signed [38:0] up_in, lo_in;
   logic [3:0]        up_idx_in, lo_idx_in;

   assign status.restart  = restart_ff;
   assign status.zero_vol = (sv_ff == '0);

   always_comb begin
      anchor_in = day_ff;
      if (tod_ff < reset_time_ff && day_ff != '0) anchor_in = day_ff - 1'b1;
      spv_sum_in  = {1'b0, spv_ff} + {17'd0, pv_ff};
      sv_sum_in   = {1'b0, sv_ff} + {25'd0, vol_ff};
      rem_sh_in   = {rem_ff, quo_ff[63]};
      dev_in      = (price_ff >= vwap_ff) ? price_ff - vwap_ff : vwap_ff - price_ff;
      term_in     = {phi_ff, 24'd0} + {24'd0, plo_ff};
      term_sat_in = (term_in[71:64] != '0) ? '1 : term_in[63:0];
      swsd_sum_in = {1'b0, swsd_ff} + {1'b0, term_sat_in};
      trial_in    = res_ff + bit_ff;
      scale_in    = scale_ff[cmd.band_idx];
      scaled_in   = 45'(scale_in) * 45'(res_ff[31:0]) + 45'd128;
      band_mag_in = scaled_in[44:8];
      up_in       = $signed({15'd0, vwap_ff}) + $signed({2'b00, band_mag_in});
      lo_in       = $signed({15'd0, vwap_ff}) - $signed({2'b00, band_mag_in});
      up_idx_in   = {cmd.band_idx, 1'b0};
      lo_idx_in   = {cmd.band_idx, 1'b1};
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         reset_time_ff <= TodW'(61200);
         for (int k = 0; k < NumBands; k++) scale_ff[k] <= ScaleW'(256 * (k + 1));
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RESET_TIME:  reset_time_ff <= csr_data;
            CSR_SCALE_ONE:   scale_ff[0] <= csr_data[ScaleW-1:0];
            CSR_SCALE_TWO:   scale_ff[1] <= csr_data[ScaleW-1:0];
            CSR_SCALE_THREE: scale_ff[2] <= csr_data[ScaleW-1:0];
            CSR_SCALE_FOUR:  scale_ff[3] <= csr_data[ScaleW-1:0];
            CSR_SCALE_FIVE:  scale_ff[4] <= csr_data[ScaleW-1:0];
            default: ;
         endcase
      end
   end

   // Session state and result register, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff     <= 1'b0;
         last_day_ff <= '0;
         spv_ff      <= '0;
         sv_ff       <= '0;
         swsd_ff     <= '0;
         vwap_out_ff <= '0;
         held_ff     <= 1'b0;
         for (int k = 0; k < 2*NumBands; k++) out_ff[k] <= '0;
      end else begin
         case (cmd.op)
            OP_ANCHOR: begin
               seen_ff     <= 1'b1;
               last_day_ff <= anchor_in;
            end
            OP_SUM: begin
               if (restart_ff) begin
                  spv_ff  <= {16'd0, pv_ff};
                  sv_ff   <= {24'd0, vol_ff};
                  swsd_ff <= '0;
               end else begin
                  spv_ff <= spv_sum_in[SpvW] ? '1 : spv_sum_in[SpvW-1:0];
                  sv_ff  <= sv_sum_in[SvW] ? '1 : sv_sum_in[SvW-1:0];
               end
            end
            OP_ACC: swsd_ff <= swsd_sum_in[SpvW] ? '1 : swsd_sum_in[SpvW-1:0];
            OP_WRITE: begin
               held_ff <= cmd.hold;
               // A held word repeats the previous results unchanged.
               if (!cmd.hold) begin
                  vwap_out_ff <= vwap_ff;
                  for (int k = 0; k < 2*NumBands; k++) out_ff[k] <= band_ff[k];
               end
            end
            default: ;
         endcase
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            price_ff <= bar_price;
            vol_ff   <= bar_volume;
            day_ff   <= day_number;
            tod_ff   <= time_of_day;
         end
         OP_ANCHOR: begin
            restart_ff <= !seen_ff || (anchor_in > last_day_ff);
            pv_ff      <= price_ff * vol_ff;
         end
         OP_DIV_SPV: begin
            quo_ff <= spv_ff;
            rem_ff <= '0;
         end
         OP_DIV_DEV: begin
            quo_ff <= swsd_ff;
            rem_ff <= '0;
         end
         OP_DIV_STEP: begin
            if (rem_sh_in >= {1'b0, sv_ff}) begin
               rem_ff <= SvW'(rem_sh_in - {1'b0, sv_ff});
               quo_ff <= {quo_ff[62:0], 1'b1};
            end else begin
               rem_ff <= rem_sh_in[SvW-1:0];
               quo_ff <= {quo_ff[62:0], 1'b0};
            end
         end
         OP_VWAP: vwap_ff <= (quo_ff[63:PriceW] != '0) ? '1 : quo_ff[PriceW-1:0];
         OP_DEV: dsq_ff <= dev_in * dev_in;
         OP_PROD_LO: plo_ff <= vol_ff * dsq_ff[23:0];
         OP_PROD_HI: phi_ff <= vol_ff * dsq_ff[47:24];
         OP_SQRT_INIT: begin
            x_ff   <= quo_ff;
            res_ff <= '0;
            bit_ff <= 64'd1 << 62;
         end
         OP_SQRT_STEP: begin
            if (x_ff >= trial_in) begin
               x_ff   <= x_ff - trial_in;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         OP_BAND: begin
            band_ff[up_idx_in] <= (up_in > 39'sh7FFFFFFF) ? 32'sh7FFFFFFF
                                                          : up_in[31:0];
            band_ff[lo_idx_in] <= (lo_in < -39'sh80000000) ? 32'sh80000000
                                                           : lo_in[31:0];
         end
         default: ;
      endcase
   end

   assign vwap  = vwap_out_ff;
   assign bands = out_ff;
   assign held  = held_ff;

endmodule

// File: hw/rtl/session_vwap_with_deviation_bands_unit.sv
// Top level of the session VWAP unit with five deviation band pairs.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  bar price, volume, day, time of day
//   rsp      out        rsp_valid / rsp_ready  vwap, ten bands, held flag
//   csr      in         csr_valid / csr_ready  register index, write data
//
// One word at a time, through two 64-step passes of the shared restoring divider and a
// 32-step square root; a session restart skips the deviation steps before the second
// pass, and a held word skips the divider and the square root.
// Reset is synchronous and clears the session sums and the last results.
// The result register frees the input side: a new word is taken while a result waits,
// and the final step waits only if the previous result is still untaken.
`timescale 1ns / 1ps
module session_vwap_with_deviation_bands_unit import svwap_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [PriceW-1:0]       req_bar_price,
   input  logic [VolW-1:0]         req_bar_volume,
   input  logic [DayW-1:0]         req_day_number,
   input  logic [TodW-1:0]         req_time_of_day,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [PriceW-1:0]       rsp_vwap,
   output logic signed [BandW-1:0] rsp_upper_one,
   output logic signed [BandW-1:0] rsp_lower_one,
   output logic signed [BandW-1:0] rsp_upper_two,
   output logic signed [BandW-1:0] rsp_lower_two,
   output logic signed [BandW-1:0] rsp_upper_three,
   output logic signed [BandW-1:0] rsp_lower_three,
   output logic signed [BandW-1:0] rsp_upper_four,
   output logic signed [BandW-1:0] rsp_lower_four,
   output logic signed [BandW-1:0] rsp_upper_five,
   output logic signed [BandW-1:0] rsp_lower_five,
   output logic                    rsp_held,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CsrIdxW-1:0]      csr_index,
   input  logic [CsrDatW-1:0]      csr_data
);

   cmd_type    cmd;
   status_type status;
   logic signed [BandW-1:0] bands [2*NumBands];

   assign csr_ready = 1'b1;

   svwap_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   svwap_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .csr_we      (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .bar_price   (req_bar_price),
      .bar_volume  (req_bar_volume),
      .day_number  (req_day_number),
      .time_of_day (req_time_of_day),
      .vwap        (rsp_vwap),
      .bands       (bands),
      .held        (rsp_held)
   );

   assign rsp_upper_one   = bands[0];
   assign rsp_lower_one   = bands[1];
   assign rsp_upper_two   = bands[2];
   assign rsp_lower_two   = bands[3];
   assign rsp_upper_three = bands[4];
   assign rsp_lower_three = bands[5];
   assign rsp_upper_four  = bands[6];
   assign rsp_lower_four  = bands[7];
   assign rsp_upper_five  = bands[8];
   assign rsp_lower_five  = bands[9];

endmodule

// File: hw/rtl/svwap_chk.sv
// Port-level checks for the session VWAP unit, bound to the top level.
`timescale 1ns / 1ps
module svwap_chk (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_held
);

   // The unit works on one word at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while a word is in progress");

   // A result appears as the sequencer returns to idle.
   a_result_at_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("result raised while still busy");

   a_no_result_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_held))
      else $error("result dropped or changed while stalled");

endmodule

bind session_vwap_with_deviation_bands_unit svwap_chk u_svwap_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_held  (rsp_held)
);
